[src/ialm_pkg.sv]
// ----------------------------------------------------------------------------
// ialm_pkg - shared types and constants of the ASCII level mapper
// Holds the cell count, derived widths, register indexes and FSM encoding.
// ----------------------------------------------------------------------------
package ialm_pkg;

  // Number of cell accumulators held in the block
  localparam int unsigned CELLS   = 64;
  localparam int unsigned CELL_AW = (CELLS > 1) ? $clog2(CELLS) : 1;
  // Largest usable cells_per_row value
  localparam int unsigned CPR_MAX = (CELLS < 64) ? CELLS : 64;

  localparam int unsigned SUM_W   = 26;
  localparam logic [SUM_W-1:0] SUM_MAX = '1;

  // Register indexes on the configuration port
  localparam logic [2:0] REG_SOURCE_WIDTH    = 3'd0;
  localparam logic [2:0] REG_IMAGE_HEIGHT    = 3'd1;
  localparam logic [2:0] REG_COMPONENT_COUNT = 3'd2;
  localparam logic [2:0] REG_PIXELS_PER_CELL = 3'd3;
  localparam logic [2:0] REG_LINES_PER_BAND  = 3'd4;
  localparam logic [2:0] REG_CELLS_PER_ROW   = 3'd5;
  localparam logic [2:0] REG_PALETTE_LAST    = 3'd6;

  // Sequencer states, one-hot
  typedef enum logic [10:0] {
    ST_IDLE  = 11'b000_0000_0001,
    ST_DIVC  = 11'b000_0000_0010,
    ST_READ  = 11'b000_0000_0100,
    ST_ACCUM = 11'b000_0000_1000,
    ST_MUL1  = 11'b000_0001_0000,
    ST_MUL2  = 11'b000_0010_0000,
    ST_DIFF  = 11'b000_0100_0000,
    ST_MUL3  = 11'b000_1000_0000,
    ST_DIVL  = 11'b001_0000_0000,
    ST_WOUT  = 11'b010_0000_0000,
    ST_ADV   = 11'b100_0000_0000
  } state_e;

endpackage

[src/image_to_ascii_level_mapper.sv]
// ----------------------------------------------------------------------------
// image_to_ascii_level_mapper - box-filter downscaler to palette levels
// Sums raster-order pixels into per-cell accumulators and emits one palette
// level per finished cell, using one shared multiplier and one shared
// restoring-division subtractor under a small sequencer.
// ----------------------------------------------------------------------------
//
//  channel  | valid / ready            | payload
//  ---------+--------------------------+--------------------------------------
//  pixel in | in_valid_i / in_ready_o  | sample_a_i, sample_b_i, sample_c_i
//  level out| out_valid_o / out_ready_i| level_o, cell_index_o, band_index_o,
//           |                          | row_end_o
//  config   | cfg_valid_i / cfg_ready_o| cfg_index_i, cfg_data_i
//
//  A pixel steps through accept, read, accumulate and advance, since the
//  accumulator read is registered; a pixel beyond the last cell skips the add.
//  Closing a cell adds three multiplier passes, one difference step, ten
//  division steps and one output load. The first pixel after a config
//  transfer first rebuilds the cell column by division. A waiting level
//  stalls only the next output load. Reset clears counters and empties cells.
//
module image_to_ascii_level_mapper (
  input  logic        clk_i,
  input  logic        rst_ni,
  // pixel input
  input  logic        in_valid_i,
  output logic        in_ready_o,
  input  logic [7:0]  sample_a_i,
  input  logic [7:0]  sample_b_i,
  input  logic [7:0]  sample_c_i,
  // level output
  output logic        out_valid_o,
  input  logic        out_ready_i,
  output logic [9:0]  level_o,
  output logic [5:0]  cell_index_o,
  output logic [11:0] band_index_o,
  output logic        row_end_o,
  // configuration writes
  input  logic        cfg_valid_i,
  output logic        cfg_ready_o,
  input  logic [2:0]  cfg_index_i,
  input  logic [12:0] cfg_data_i
);

  localparam int unsigned AW = ialm_pkg::CELL_AW;
  localparam int unsigned SW = ialm_pkg::SUM_W;

  // --------------------------------------------------------------------------
  // Configuration registers (raw values, clamped below)
  // --------------------------------------------------------------------------
  logic [12:0] src_w_q, img_h_q;
  logic [1:0]  comps_q;
  logic [8:0]  ppc_q, lpb_q;
  logic [6:0]  cpr_q;
  logic [9:0]  pal_q;
  logic        cfg_wr;

  assign cfg_ready_o = 1'b1;
  assign cfg_wr      = cfg_valid_i & cfg_ready_o;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      src_w_q <= 13'd640;
      img_h_q <= 13'd480;
      comps_q <= 2'd1;
      ppc_q   <= 9'd8;
      lpb_q   <= 9'd19;
      cpr_q   <= 7'd64;
      pal_q   <= 10'd22;
    end else if (cfg_wr) begin
      unique case (cfg_index_i)
        ialm_pkg::REG_SOURCE_WIDTH:    src_w_q <= cfg_data_i;
        ialm_pkg::REG_IMAGE_HEIGHT:    img_h_q <= cfg_data_i;
        ialm_pkg::REG_COMPONENT_COUNT: comps_q <= cfg_data_i[1:0];
        ialm_pkg::REG_PIXELS_PER_CELL: ppc_q   <= cfg_data_i[8:0];
        ialm_pkg::REG_LINES_PER_BAND:  lpb_q   <= cfg_data_i[8:0];
        ialm_pkg::REG_CELLS_PER_ROW:   cpr_q   <= cfg_data_i[6:0];
        ialm_pkg::REG_PALETTE_LAST:    pal_q   <= cfg_data_i[9:0];
        default: ;
      endcase
    end
  end

  // Clamped views: zero counts as one, values above the bound as the bound
  logic [12:0] src_w_m1, img_h_m1;
  logic [11:0] w_last, h_last;
  logic [8:0]  lpb_m1, ppc_c, ppc_m1w;
  logic [7:0]  lpb_last, ppc_last;
  logic [1:0]  comps_c;
  logic [6:0]  cpr_lim, cpr_m1;
  logic [9:0]  comps_255;

  always_comb begin
    src_w_m1 = src_w_q - 13'd1;
    img_h_m1 = img_h_q - 13'd1;
    lpb_m1   = lpb_q - 9'd1;
    w_last   = (src_w_q == '0) ? '0 : (src_w_q > 13'd4096) ? '1 : src_w_m1[11:0];
    h_last   = (img_h_q == '0) ? '0 : (img_h_q > 13'd4096) ? '1 : img_h_m1[11:0];
    lpb_last = (lpb_q == '0) ? '0 : (lpb_q > 9'd256) ? '1 : lpb_m1[7:0];
    ppc_c    = (ppc_q == '0) ? 9'd1 : (ppc_q > 9'd256) ? 9'd256 : ppc_q;
    ppc_m1w  = ppc_c - 9'd1;
    ppc_last = ppc_m1w[7:0];
    comps_c  = (comps_q == '0) ? 2'd1 : comps_q;
    cpr_lim  = (cpr_q == '0) ? 7'd1 :
               (cpr_q > 7'(ialm_pkg::CPR_MAX)) ? 7'(ialm_pkg::CPR_MAX) : cpr_q;
    cpr_m1   = cpr_lim - 7'd1;
    // components * 255
    comps_255 = {comps_c, 8'd0} - {8'd0, comps_c};
  end

  // --------------------------------------------------------------------------
  // Sequencer and datapath registers
  // --------------------------------------------------------------------------
  ialm_pkg::state_e state_q, state_d;

  logic [11:0] col_q, col_d, row_q, row_d, band_q, band_d, cell_q, cell_d;
  logic [7:0]  rib_q, rib_d, phase_q, phase_d;
  logic        stale_q, stale_d;
  logic        row_last_q, row_last_d, band_last_q, band_last_d;
  logic        img_last_q, img_last_d;
  logic [9:0]  pix_q, pix_d;

  // shared division unit
  logic [3:0]    cnt_q, cnt_d;
  logic [SW-1:0] rem_q, rem_d, dvs_q, dvs_d;
  logic [35:0]   num_q, num_d;
  logic [11:0]   quo_q, quo_d;
  logic [27:0]   step_sub;
  logic          step_ge;
  logic [SW-1:0] rem_nx;
  logic [11:0]   quo_nx;

  // shared multiplier
  logic [SW-1:0] mul_a;
  logic [9:0]    mul_b;
  logic [35:0]   mul_p;
  logic [17:0]   prod_q, prod_d;
  logic [SW-1:0] diff_q, diff_d, sum_q, sum_d;

  // accumulator memory
  logic [SW-1:0]              sums_mem [ialm_pkg::CELLS];
  logic [SW-1:0]              rd_q;
  logic [ialm_pkg::CELLS-1:0] sum_vld_q, sum_vld_d;
  logic [AW-1:0]              addr;
  logic                       mem_rd, mem_wr;
  logic [SW-1:0]              mem_wdata, cur_sum, acc_sat;
  logic [SW:0]                acc_sum;

  // output register
  logic        out_valid_q, out_valid_d;
  logic [9:0]  level_q, level_d;
  logic [5:0]  cidx_q, cidx_d;
  logic [11:0] bidx_q, bidx_d;
  logic        rend_q, rend_d;
  logic        out_load;

  logic        in_xfer, in_range, emit;
  logic [8:0]  phase_p1, rib_p1;

  assign in_ready_o = (state_q == ialm_pkg::ST_IDLE);
  assign in_xfer    = in_valid_i & in_ready_o;
  assign addr       = cell_q[AW-1:0];
  assign in_range   = cell_q < {5'd0, cpr_lim};
  assign emit       = ((phase_q == ppc_last) || row_last_q) && (band_last_q || img_last_q);
  assign phase_p1   = {1'b0, phase_q} + 9'd1;
  assign rib_p1     = {1'b0, rib_q} + 9'd1;

  // One restoring-division step: shift in the next dividend bit, try subtract
  always_comb begin
    step_sub = {1'b0, rem_q, num_q[35]} - {2'd0, dvs_q};
    step_ge  = ~step_sub[27];
    rem_nx   = step_ge ? step_sub[SW-1:0] : {rem_q[SW-2:0], num_q[35]};
    quo_nx   = {quo_q[10:0], step_ge};
  end

  // Multiplier operand select
  always_comb begin
    mul_a = '0;
    mul_b = '0;
    unique case (state_q)
      ialm_pkg::ST_MUL1: begin  // pixels times lines
        mul_a = {17'd0, phase_p1};
        mul_b = {1'b0, rib_p1};
      end
      ialm_pkg::ST_MUL2: begin  // times components * 255
        mul_a = {8'd0, prod_q};
        mul_b = comps_255;
      end
      ialm_pkg::ST_MUL3: begin  // palette_last times difference
        mul_a = diff_q;
        mul_b = pal_q;
      end
      default: ;
    endcase
    mul_p = 36'(mul_a) * 36'(mul_b);
  end

  // Saturating accumulate; a cell never written reads as zero
  always_comb begin
    cur_sum = sum_vld_q[addr] ? rd_q : '0;
    acc_sum = {1'b0, cur_sum} + {17'd0, pix_q};
    acc_sat = acc_sum[SW] ? ialm_pkg::SUM_MAX : acc_sum[SW-1:0];
  end

  always_comb begin
    state_d     = state_q;
    col_d       = col_q;
    row_d       = row_q;
    band_d      = band_q;
    cell_d      = cell_q;
    rib_d       = rib_q;
    phase_d     = phase_q;
    stale_d     = stale_q | cfg_wr;
    row_last_d  = row_last_q;
    band_last_d = band_last_q;
    img_last_d  = img_last_q;
    pix_d       = pix_q;
    cnt_d       = cnt_q;
    rem_d       = rem_q;
    dvs_d       = dvs_q;
    num_d       = num_q;
    quo_d       = quo_q;
    prod_d      = prod_q;
    diff_d      = diff_q;
    sum_d       = sum_q;
    sum_vld_d   = sum_vld_q;
    mem_rd      = 1'b0;
    mem_wr      = 1'b0;
    mem_wdata   = acc_sat;
    out_load    = 1'b0;
    level_d     = level_q;
    cidx_d      = cidx_q;
    bidx_d      = bidx_q;
    rend_d      = rend_q;

    unique case (state_q)
      ialm_pkg::ST_IDLE: begin
        if (in_xfer) begin
          // capture the pixel sum and the row, band and image end flags
          pix_d = {2'd0, sample_a_i}
                + ((comps_c >= 2'd2) ? {2'd0, sample_b_i} : 10'd0)
                + ((comps_c == 2'd3) ? {2'd0, sample_c_i} : 10'd0);
          row_last_d  = col_q >= w_last;
          img_last_d  = row_q >= h_last;
          band_last_d = rib_q >= lpb_last;
          if (stale_q) begin
            // rebuild cell and phase from the column position
            rem_d   = '0;
            num_d   = {col_q, 24'd0};
            dvs_d   = {17'd0, ppc_c};
            cnt_d   = 4'd12;
            state_d = ialm_pkg::ST_DIVC;
          end else begin
            state_d = ialm_pkg::ST_READ;
          end
        end
      end
      ialm_pkg::ST_DIVC: begin
        rem_d = rem_nx;
        quo_d = quo_nx;
        num_d = {num_q[34:0], 1'b0};
        cnt_d = cnt_q - 4'd1;
        if (cnt_q == 4'd1) begin
          cell_d  = quo_nx;
          phase_d = rem_nx[7:0];
          stale_d = cfg_wr;
          state_d = ialm_pkg::ST_READ;
        end
      end
      ialm_pkg::ST_READ: begin
        if (in_range) begin
          mem_rd  = 1'b1;
          state_d = ialm_pkg::ST_ACCUM;
        end else begin
          // beyond the last cell: drop the pixel
          state_d = ialm_pkg::ST_ADV;
        end
      end
      ialm_pkg::ST_ACCUM: begin
        mem_wr          = 1'b1;
        mem_wdata       = emit ? '0 : acc_sat;
        sum_vld_d[addr] = 1'b1;
        sum_d           = acc_sat;
        state_d         = emit ? ialm_pkg::ST_MUL1 : ialm_pkg::ST_ADV;
      end
      ialm_pkg::ST_MUL1: begin
        prod_d  = mul_p[17:0];
        state_d = ialm_pkg::ST_MUL2;
      end
      ialm_pkg::ST_MUL2: begin
        dvs_d   = mul_p[SW-1:0];
        state_d = ialm_pkg::ST_DIFF;
      end
      ialm_pkg::ST_DIFF: begin
        // saturate the difference at zero
        diff_d  = (sum_q > dvs_q) ? '0 : dvs_q - sum_q;
        state_d = ialm_pkg::ST_MUL3;
      end
      ialm_pkg::ST_MUL3: begin
        // quotient fits ten bits, so start with the top of the dividend
        rem_d   = mul_p[35:10];
        num_d   = {mul_p[9:0], 26'd0};
        cnt_d   = 4'd10;
        state_d = ialm_pkg::ST_DIVL;
      end
      ialm_pkg::ST_DIVL: begin
        rem_d = rem_nx;
        quo_d = quo_nx;
        num_d = {num_q[34:0], 1'b0};
        cnt_d = cnt_q - 4'd1;
        if (cnt_q == 4'd1) begin
          state_d = ialm_pkg::ST_WOUT;
        end
      end
      ialm_pkg::ST_WOUT: begin
        // hold until the previous level has been taken
        if (!out_valid_q || out_ready_i) begin
          out_load = 1'b1;
          level_d  = quo_q[9:0];
          cidx_d   = cell_q[5:0];
          bidx_d   = band_q;
          rend_d   = (cell_q == {5'd0, cpr_m1}) || row_last_q;
          state_d  = ialm_pkg::ST_ADV;
        end
      end
      ialm_pkg::ST_ADV: begin
        // advance the raster position
        if (row_last_q) begin
          col_d   = '0;
          cell_d  = '0;
          phase_d = '0;
          if (img_last_q) begin
            row_d  = '0;
            rib_d  = '0;
            band_d = '0;
          end else begin
            row_d = row_q + 12'd1;
            if (band_last_q) begin
              rib_d  = '0;
              band_d = band_q + 12'd1;
            end else begin
              rib_d = rib_q + 8'd1;
            end
          end
        end else begin
          col_d = col_q + 12'd1;
          if (phase_q == ppc_last) begin
            phase_d = '0;
            cell_d  = cell_q + 12'd1;
          end else begin
            phase_d = phase_q + 8'd1;
          end
        end
        state_d = ialm_pkg::ST_IDLE;
      end
      default: state_d = ialm_pkg::ST_IDLE;
    endcase

    out_valid_d = out_load | (out_valid_q & ~out_ready_i);
  end

  // Control state
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q     <= ialm_pkg::ST_IDLE;
      col_q       <= '0;
      row_q       <= '0;
      band_q      <= '0;
      cell_q      <= '0;
      rib_q       <= '0;
      phase_q     <= '0;
      stale_q     <= 1'b0;
      row_last_q  <= 1'b0;
      band_last_q <= 1'b0;
      img_last_q  <= 1'b0;
      cnt_q       <= '0;
      sum_vld_q   <= '0;
      out_valid_q <= 1'b0;
    end else begin
      state_q     <= state_d;
      col_q       <= col_d;
      row_q       <= row_d;
      band_q      <= band_d;
      cell_q      <= cell_d;
      rib_q       <= rib_d;
      phase_q     <= phase_d;
      stale_q     <= stale_d;
      row_last_q  <= row_last_d;
      band_last_q <= band_last_d;
      img_last_q  <= img_last_d;
      cnt_q       <= cnt_d;
      sum_vld_q   <= sum_vld_d;
      out_valid_q <= out_valid_d;
    end
  end

  // Payload registers
  always_ff @(posedge clk_i) begin
    pix_q   <= pix_d;
    rem_q   <= rem_d;
    dvs_q   <= dvs_d;
    num_q   <= num_d;
    quo_q   <= quo_d;
    prod_q  <= prod_d;
    diff_q  <= diff_d;
    sum_q   <= sum_d;
    level_q <= level_d;
    cidx_q  <= cidx_d;
    bidx_q  <= bidx_d;
    rend_q  <= rend_d;
  end

  // Accumulator memory: one write port, one registered read port
  always_ff @(posedge clk_i) begin
    if (mem_wr) begin
      sums_mem[addr] <= mem_wdata;
    end
    if (mem_rd) begin
      rd_q <= sums_mem[addr];
    end
  end

  assign out_valid_o  = out_valid_q;
  assign level_o      = level_q;
  assign cell_index_o = cidx_q;
  assign band_index_o = bidx_q;
  assign row_end_o    = rend_q;

  // --------------------------------------------------------------------------
  // Assertions
  // --------------------------------------------------------------------------
  a_accept_next: assert property (@(posedge clk_i) disable iff (!rst_ni)
    in_xfer |=> (state_q == ialm_pkg::ST_DIVC || state_q == ialm_pkg::ST_READ))
    else $error("accepted pixel did not enter division or read");

  a_div_count: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (state_q == ialm_pkg::ST_DIVC || state_q == ialm_pkg::ST_DIVL) |-> cnt_q != 4'd0)
    else $error("division running with zero step count");

  a_rem_bound: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (state_q == ialm_pkg::ST_DIVL) |-> rem_q < dvs_q)
    else $error("level division remainder not below divisor");

  a_load_src: assert property (@(posedge clk_i) disable iff (!rst_ni)
    $rose(out_valid_q) |-> $past(state_q == ialm_pkg::ST_WOUT))
    else $error("level presented outside the output load state");

endmodule

[tb/sv/ialm_level_checker.sv]
`timescale 1ns / 100ps
// ----------------------------------------------------------------------------
// ialm_level_checker - scoreboard for the ASCII level mapper
// Watches the pixel, level and configuration channels, keeps its own copy of
// the cell accumulators and raster position, and compares every level
// transfer with the oldest predicted cell level.
// ----------------------------------------------------------------------------
module ialm_level_checker (
  input  logic              clk_i,
  input  logic              rst_ni,
  input  logic              in_valid_i,
  input  logic              in_ready_i,
  input  logic [7:0]        sample_a_i,
  input  logic [7:0]        sample_b_i,
  input  logic [7:0]        sample_c_i,
  input  logic              out_valid_i,
  input  logic              out_ready_i,
  input  logic [9:0]        level_i,
  input  logic [5:0]        cell_index_i,
  input  logic [11:0]       band_index_i,
  input  logic              row_end_i,
  input  logic              cfg_valid_i,
  input  logic              cfg_ready_i,
  input  logic [2:0]        cfg_index_i,
  input  logic [12:0]       cfg_data_i,
  output int unsigned       fail_count_o,
  output int unsigned       levels_waiting_o
);

  typedef struct packed {
    logic [9:0]  level;
    logic [5:0]  column;
    logic [11:0] band;
    logic        row_end;
  } cell_level_t;

  logic [12:0]      src_width;
  logic [12:0]      img_height;
  logic [1:0]       comp_count;
  logic [8:0]       cell_pixels;
  logic [8:0]       band_lines;
  logic [6:0]       row_cells;
  logic [9:0]       pal_last;

  logic [ialm_pkg::SUM_W-1:0] cell_acc [ialm_pkg::CELLS];
  logic [11:0]      col_pos;
  logic [11:0]      row_pos;
  logic [7:0]       band_row;
  logic [11:0]      band_no;

  cell_level_t      levels_due [$];
  int unsigned      fails;

  function automatic int unsigned bounded(int unsigned v, int unsigned lo, int unsigned hi);
    if (v < lo) return lo;
    if (v > hi) return hi;
    return v;
  endfunction

  function automatic void restore_reset();
    src_width   = 13'd640;
    img_height  = 13'd480;
    comp_count  = 2'd1;
    cell_pixels = 9'd8;
    band_lines  = 9'd19;
    row_cells   = 7'd64;
    pal_last    = 10'd22;
    foreach (cell_acc[i]) cell_acc[i] = '0;
    col_pos  = '0;
    row_pos  = '0;
    band_row = '0;
    band_no  = '0;
    levels_due.delete();
    fails = 0;
  endfunction

  function automatic void take_register(logic [2:0] idx, logic [12:0] data);
    case (idx)
      ialm_pkg::REG_SOURCE_WIDTH:    src_width   = data;
      ialm_pkg::REG_IMAGE_HEIGHT:    img_height  = data;
      ialm_pkg::REG_COMPONENT_COUNT: comp_count  = data[1:0];
      ialm_pkg::REG_PIXELS_PER_CELL: cell_pixels = data[8:0];
      ialm_pkg::REG_LINES_PER_BAND:  band_lines  = data[8:0];
      ialm_pkg::REG_CELLS_PER_ROW:   row_cells   = data[6:0];
      ialm_pkg::REG_PALETTE_LAST:    pal_last    = data[9:0];
      default: ;
    endcase
  endfunction

  // Add one pixel to its cell and queue the cell's level when the pixel closes it.
  function automatic void absorb_pixel(logic [7:0] a, logic [7:0] b, logic [7:0] c);
    int unsigned       wid, hgt, comps, ppc, lpb, cpr;
    int unsigned       pix, slot, phase, acc;
    bit                row_last, band_last, image_last;
    longint unsigned   divisor, shortfall, lvl;
    cell_level_t       due;
    wid   = bounded(src_width, 1, 4096);
    hgt   = bounded(img_height, 1, 4096);
    comps = bounded(comp_count, 1, 3);
    ppc   = bounded(cell_pixels, 1, 256);
    lpb   = bounded(band_lines, 1, 256);
    cpr   = bounded(row_cells, 1, ialm_pkg::CPR_MAX);

    pix = a;
    if (comps >= 2) pix += b;
    if (comps >= 3) pix += c;

    row_last   = col_pos >= wid - 1;
    image_last = row_pos >= hgt - 1;
    band_last  = band_row >= lpb - 1;
    slot  = col_pos / ppc;
    phase = col_pos % ppc;

    if (slot < cpr) begin
      acc = cell_acc[slot] + pix;
      if (acc > ialm_pkg::SUM_MAX) acc = ialm_pkg::SUM_MAX;
      cell_acc[slot] = acc[ialm_pkg::SUM_W-1:0];
      if ((phase == ppc - 1 || row_last) && (band_last || image_last)) begin
        divisor   = longint'(comps) * 64'd255 * (phase + 1) * (band_row + 1);
        shortfall = (acc > divisor) ? 64'd0 : divisor - acc;
        lvl       = (pal_last * shortfall) / divisor;
        due.level   = lvl[9:0];
        due.column  = slot[5:0];
        due.band    = band_no;
        due.row_end = (slot == cpr - 1) || row_last;
        levels_due.push_back(due);
        cell_acc[slot] = '0;
      end
    end

    if (row_last) begin
      col_pos = '0;
      if (image_last) begin
        row_pos  = '0;
        band_row = '0;
        band_no  = '0;
      end else begin
        row_pos = row_pos + 1;
        if (band_last) begin
          band_row = '0;
          band_no  = band_no + 1;
        end else begin
          band_row = band_row + 1;
        end
      end
    end else begin
      col_pos = col_pos + 1;
    end
  endfunction

  function automatic void compare_level();
    cell_level_t want;
    if (levels_due.size() == 0) begin
      $error("level transfer with nothing due: level %0d cell %0d band %0d row_end %0d",
             level_i, cell_index_i, band_index_i, row_end_i);
      fails++;
      return;
    end
    want = levels_due.pop_front();
    if (level_i !== want.level) begin
      $error("level: expected %0d, got %0d", want.level, level_i);
      fails++;
    end
    if (cell_index_i !== want.column) begin
      $error("cell_index: expected %0d, got %0d", want.column, cell_index_i);
      fails++;
    end
    if (band_index_i !== want.band) begin
      $error("band_index: expected %0d, got %0d", want.band, band_index_i);
      fails++;
    end
    if (row_end_i !== want.row_end) begin
      $error("row_end: expected %0d, got %0d", want.row_end, row_end_i);
      fails++;
    end
  endfunction

  always @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      restore_reset();
      fail_count_o     <= 0;
      levels_waiting_o <= 0;
    end else begin
      if (cfg_valid_i && cfg_ready_i) take_register(cfg_index_i, cfg_data_i);
      if (in_valid_i && in_ready_i) absorb_pixel(sample_a_i, sample_b_i, sample_c_i);
      if (out_valid_i && out_ready_i) compare_level();
      fail_count_o     <= fails;
      levels_waiting_o <= levels_due.size();
    end
  end

endmodule

[tb/sv/tb_image_to_ascii_level_mapper.sv]
`timescale 1ns / 100ps
// ----------------------------------------------------------------------------
// tb_image_to_ascii_level_mapper - stimulus and verdict for the level mapper
// Programs the mapper through its register port, streams raster images of
// random content and shape through the pixel port with bursty timing, and
// stalls the level port on its own pattern. The checker beside the block
// predicts every cell level and counts mismatches.
// ----------------------------------------------------------------------------
module tb_image_to_ascii_level_mapper;

  localparam real         CLK_PERIOD    = 12.0;
  // Index past the register file: the block must ignore it
  localparam logic [2:0]  REG_UNUSED    = 3'd7;
  // Worst pixel: accept/read/accumulate/advance, closing a cell, rebuilding
  // the column after a register write; round up generously
  localparam int unsigned SETTLE_CYCLES = 40;
  localparam int unsigned GAP_MAX       = 6;
  localparam int unsigned STALL_MAX     = 12;
  localparam int unsigned RANDOM_PIXELS = 1250;
  localparam longint      RUN_LIMIT_NS  = 64'd12_000_000;

  logic        clk_i       = 1'b0;
  logic        rst_ni      = 1'b0;
  logic        in_valid_i  = 1'b0;
  logic        in_ready_o;
  logic [7:0]  sample_a_i  = '0;
  logic [7:0]  sample_b_i  = '0;
  logic [7:0]  sample_c_i  = '0;
  logic        out_valid_o;
  logic        out_ready_i = 1'b0;
  logic [9:0]  level_o;
  logic [5:0]  cell_index_o;
  logic [11:0] band_index_o;
  logic        row_end_o;
  logic        cfg_valid_i = 1'b0;
  logic        cfg_ready_o;
  logic [2:0]  cfg_index_i = '0;
  logic [12:0] cfg_data_i  = '0;

  int unsigned fail_count;
  int unsigned levels_waiting;

  // Sender state: remaining transfers in the current burst, and whether
  // valid is currently scheduled high
  int unsigned burst_left = 0;
  bit          px_live    = 1'b0;

  // Receiver stall pattern state
  int unsigned go_run    = 0;
  int unsigned stall_run = 0;

  always #(CLK_PERIOD / 2) clk_i = ~clk_i;

  image_to_ascii_level_mapper dut (
    .clk_i        (clk_i),
    .rst_ni       (rst_ni),
    .in_valid_i   (in_valid_i),
    .in_ready_o   (in_ready_o),
    .sample_a_i   (sample_a_i),
    .sample_b_i   (sample_b_i),
    .sample_c_i   (sample_c_i),
    .out_valid_o  (out_valid_o),
    .out_ready_i  (out_ready_i),
    .level_o      (level_o),
    .cell_index_o (cell_index_o),
    .band_index_o (band_index_o),
    .row_end_o    (row_end_o),
    .cfg_valid_i  (cfg_valid_i),
    .cfg_ready_o  (cfg_ready_o),
    .cfg_index_i  (cfg_index_i),
    .cfg_data_i   (cfg_data_i)
  );

  ialm_level_checker u_checker (
    .clk_i            (clk_i),
    .rst_ni           (rst_ni),
    .in_valid_i       (in_valid_i),
    .in_ready_i       (in_ready_o),
    .sample_a_i       (sample_a_i),
    .sample_b_i       (sample_b_i),
    .sample_c_i       (sample_c_i),
    .out_valid_i      (out_valid_o),
    .out_ready_i      (out_ready_i),
    .level_i          (level_o),
    .cell_index_i     (cell_index_o),
    .band_index_i     (band_index_o),
    .row_end_i        (row_end_o),
    .cfg_valid_i      (cfg_valid_i),
    .cfg_ready_i      (cfg_ready_o),
    .cfg_index_i      (cfg_index_i),
    .cfg_data_i       (cfg_data_i),
    .fail_count_o     (fail_count),
    .levels_waiting_o (levels_waiting)
  );

  // Level port back-pressure: alternate short ready and stall runs, with the
  // odd long stretch of constant ready so that transfers also go back to back.
  always @(posedge clk_i) begin
    logic rdy;
    if (stall_run > 0) begin
      rdy = 1'b0;
      stall_run--;
    end else if (go_run > 0) begin
      rdy = 1'b1;
      go_run--;
    end else begin
      if ($urandom_range(3, 0) == 0) begin
        go_run    = $urandom_range(200, 50);
        stall_run = 0;
      end else begin
        go_run    = $urandom_range(8, 1);
        stall_run = $urandom_range(STALL_MAX, 0);
      end
      rdy = 1'b1;
    end
    out_ready_i <= rdy;
  end

  // One pixel transfer. Valid stays high across a burst; between bursts drop
  // it for a random gap so that idle cycles land on every sequencer state.
  task automatic send_pixel(input logic [7:0] a, input logic [7:0] b, input logic [7:0] c);
    if (!px_live) begin
      repeat ($urandom_range(GAP_MAX, 1)) @(posedge clk_i);
      burst_left = ($urandom_range(3, 0) == 0) ? $urandom_range(200, 60)
                                                : $urandom_range(12, 1);
    end
    in_valid_i <= 1'b1;
    sample_a_i <= a;
    sample_b_i <= b;
    sample_c_i <= c;
    px_live = 1'b1;
    do @(posedge clk_i); while (!in_ready_o);
    burst_left--;
    if (burst_left == 0) begin
      in_valid_i <= 1'b0;
      px_live = 1'b0;
    end
  endtask

  // Drop valid, wait for every predicted level to arrive, then give a pixel
  // that closes no cell time to leave the block before the next register write.
  task automatic pause_for_config();
    if (px_live) begin
      in_valid_i <= 1'b0;
      px_live = 1'b0;
    end
    do @(posedge clk_i); while (levels_waiting != 0);
    repeat (SETTLE_CYCLES) @(posedge clk_i);
  endtask

  task automatic write_reg(input logic [2:0] idx, input logic [12:0] data, input bit last);
    cfg_valid_i <= 1'b1;
    cfg_index_i <= idx;
    cfg_data_i  <= data;
    do @(posedge clk_i); while (!cfg_ready_o);
    if (last) cfg_valid_i <= 1'b0;
  endtask

  task automatic program_mapper(input logic [12:0] wid, input logic [12:0] hgt,
                                input logic [12:0] comps, input logic [12:0] ppc,
                                input logic [12:0] lpb, input logic [12:0] cpr,
                                input logic [12:0] pal, input bit junk);
    write_reg(ialm_pkg::REG_SOURCE_WIDTH,    wid,   1'b0);
    write_reg(ialm_pkg::REG_IMAGE_HEIGHT,    hgt,   1'b0);
    write_reg(ialm_pkg::REG_COMPONENT_COUNT, comps, 1'b0);
    write_reg(ialm_pkg::REG_PIXELS_PER_CELL, ppc,   1'b0);
    write_reg(ialm_pkg::REG_LINES_PER_BAND,  lpb,   1'b0);
    write_reg(ialm_pkg::REG_CELLS_PER_ROW,   cpr,   1'b0);
    write_reg(ialm_pkg::REG_PALETTE_LAST,    pal,   !junk);
    if (junk) write_reg(REG_UNUSED, 13'($urandom), 1'b1);
  endtask

  // Pixel brightness profile of a phase: flat random, near white, near black,
  // or hard black/white.
  function automatic logic [7:0] pick_tone(int unsigned tone);
    case (tone)
      1:       return 8'($urandom_range(255, 240));
      2:       return 8'($urandom_range(15, 0));
      3:       return $urandom_range(1, 0) ? 8'hFF : 8'h00;
      default: return 8'($urandom_range(255, 0));
    endcase
  endfunction

  task automatic feed(input int unsigned count, input int unsigned tone);
    for (int unsigned i = 0; i < count; i++)
      send_pixel(pick_tone(tone), pick_tone(tone), pick_tone(tone));
  endtask

  initial begin : stimulus
    int unsigned  mode, tone, count, w_eff, h_eff, random_sent;
    logic [12:0]  wid, hgt, ppc, lpb, cpr, pal;
    random_sent = 0;

    repeat (4) @(posedge clk_i);
    rst_ni <= 1'b1;
    @(posedge clk_i);

    // Three-component 3x2 image, one full cell plus a partial cell at each row end,
    // one-line bands, full palette; extreme and alternating sample bits.
    program_mapper(13'd3, 13'd2, 13'd3, 13'd2, 13'd1, 13'd64, 13'd1023, 1'b0);
    send_pixel(8'h00, 8'h00, 8'h00);
    send_pixel(8'hFF, 8'hFF, 8'hFF);
    send_pixel(8'hFF, 8'h00, 8'h80);
    send_pixel(8'h00, 8'hFF, 8'h01);
    send_pixel(8'hAA, 8'h55, 8'hFE);
    send_pixel(8'h55, 8'hAA, 8'h7F);
    pause_for_config();

    // Part of a row with a zero cell count (one cell), then narrow the row and
    // drop to one component mid-band: the column is past the new row end, and
    // the closing cell holds more than its divisor, so the level floors at 0.
    program_mapper(13'd5, 13'd3, 13'd3, 13'd2, 13'd2, 13'd0, 13'd0, 1'b0);
    repeat (3) send_pixel(8'hFF, 8'hFF, 8'hFF);
    pause_for_config();
    program_mapper(13'd2, 13'd3, 13'd0, 13'd2, 13'd2, 13'd0, 13'd1023, 1'b0);
    repeat (3) send_pixel(8'hFF, 8'hFF, 8'hFF);
    pause_for_config();

    // Image shorter than the current row: the next pixel ends the image and
    // returns the band count to zero. Zero width, cell size and band height.
    program_mapper(13'd0, 13'd1, 13'd1, 13'd0, 13'd0, 13'd5, 13'd700, 1'b0);
    send_pixel(8'h80, 8'h01, 8'hFE);
    send_pixel(8'h7F, 8'hFE, 8'h01);
    pause_for_config();

    // Over-range values and zeros, and stray high data bits; junk index too.
    program_mapper(13'd0, 13'd8191, 13'h1FFE, 13'd511, 13'd0, 13'd127, 13'h1FFF, 1'b1);
    send_pixel(8'hFF, 8'hFF, 8'h00);
    send_pixel(8'h00, 8'h00, 8'hFF);
    send_pixel(8'h01, 8'h80, 8'h55);
    send_pixel(8'hFE, 8'h7F, 8'hAA);
    pause_for_config();

    // Random phases. Mostly whole small images so that many cells close;
    // now and then a wide row or a deep band with large register values, and
    // images cut short so that the next phase starts in mid-image.
    while (random_sent < RANDOM_PIXELS) begin
      mode = $urandom_range(11, 0);
      tone = ($urandom_range(2, 0) == 0) ? $urandom_range(3, 1) : 0;
      pal  = ($urandom_range(3, 0) == 0) ? ($urandom_range(1, 0) ? 13'd1023 : 13'd0)
                                         : 13'($urandom_range(8191, 0));
      if (mode == 0) begin
        wid   = ($urandom_range(2, 0) == 0) ? 13'd4096 : 13'($urandom_range(8191, 257));
        hgt   = 13'($urandom_range(3, 0));
        ppc   = 13'($urandom_range(511, 128));
        lpb   = 13'($urandom_range(2, 0));
        cpr   = 13'($urandom_range(127, 0));
        count = $urandom_range(400, 200);
      end else if (mode == 1) begin
        wid   = 13'($urandom_range(3, 1));
        hgt   = 13'($urandom_range(8191, 0));
        ppc   = 13'($urandom_range(4, 0));
        lpb   = 13'($urandom_range(511, 0));
        cpr   = 13'($urandom_range(8, 0));
        count = $urandom_range(120, 20);
      end else begin
        wid   = ($urandom_range(9, 0) == 0) ? 13'd0 : 13'($urandom_range(12, 1));
        hgt   = ($urandom_range(9, 0) == 0) ? 13'd0 : 13'($urandom_range(8, 1));
        ppc   = 13'($urandom_range(5, 0));
        lpb   = 13'($urandom_range(4, 0));
        case ($urandom_range(9, 0))
          0:       cpr = 13'd0;
          1:       cpr = 13'($urandom_range(127, 64));
          default: cpr = 13'($urandom_range(8, 1));
        endcase
        w_eff = (wid == 0) ? 1 : wid;
        h_eff = (hgt == 0) ? 1 : hgt;
        count = w_eff * h_eff * $urandom_range(3, 1);
        if ($urandom_range(3, 0) == 0 && count > 1) count = $urandom_range(count - 1, 1);
      end
      program_mapper(wid, hgt, 13'($urandom_range(8191, 0)), ppc, lpb, cpr, pal,
                     $urandom_range(3, 0) == 0);
      feed(count, tone);
      random_sent += count;
      pause_for_config();
    end

    if (fail_count == 0) begin
      $display("tb_image_to_ascii_level_mapper: clean");
    end else begin
      $display("tb_image_to_ascii_level_mapper: errors");
    end
    $finish;
  end

  // Hard stop well beyond the slowest legal run.
  initial begin : watchdog
    #(RUN_LIMIT_NS);
    $display("tb_image_to_ascii_level_mapper: errors");
    $finish;
  end

endmodule

[filelist.f]
src/ialm_pkg.sv
src/image_to_ascii_level_mapper.sv
tb/sv/ialm_level_checker.sv
tb/sv/tb_image_to_ascii_level_mapper.sv
